/* design/robin_hood_hash_map_macros.svh */
// Assertion macros shared by the hash map design.
`ifndef ROBIN_HOOD_HASH_MAP_MACROS_SVH
`define ROBIN_HOOD_HASH_MAP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RHH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RHH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/rhh_pkg.sv */
// Shared types, constants and helpers for the Robin Hood hash map.
package rhh_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 11'd819;
  localparam logic [63:0] HASH_C1 = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] HASH_C2 = 64'h94D049BB133111EB;
  localparam logic [7:0] DIST_MAX = 8'd255;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_HIT      = 3'd2,
    ST_MISS     = 3'd3,
    ST_REMOVED  = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_MOD,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_EVAL,
    B_SREAD,
    B_SEVAL,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  pdist;
    logic [31:0] value;
    logic [63:0] key;
  } rhh_entry_t;

  typedef struct packed {
    logic clearing;
    logic busy;
    logic load;
  } rhh_stat_t;

  function automatic logic [7:0] dist_bump(input logic [7:0] d);
    return (d == DIST_MAX) ? DIST_MAX : d + 8'd1;
  endfunction

  function automatic logic [7:0] dist_dec(input logic [7:0] d);
    return (d == DIST_MAX) ? DIST_MAX : d - 8'd1;
  endfunction

endpackage

/* design/rhh_front.sv */
// Front end: accepts requests, hashes the key and reduces it to a home slot.
module rhh_front #(
  parameter int CAPACITY = rhh_pkg::CAPACITY_DEF,
  parameter int AW = $clog2(CAPACITY)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    req_type,
  input  logic [63:0]   key,
  input  logic [31:0]   value_index,
  output logic          push_valid,
  input  logic          push_ready,
  output logic [1:0]    push_req,
  output logic [63:0]   push_key,
  output logic [31:0]   push_value,
  output logic [AW-1:0] push_home
);
  import rhh_pkg::*;

  localparam bit POW2 = (CAPACITY == (1 << AW));
  localparam logic [AW:0] CAPW = (AW+1)'(CAPACITY);
  localparam logic [63:0] CAP64 = 64'(CAPACITY);
  localparam logic [63:0] R32 = (64'd1 << 32) % CAP64;
  localparam logic [63:0] BM = (64'd1 << 32) / CAP64;
  localparam logic [31:0] R32W = R32[31:0];
  localparam logic [31:0] BMW = BM[31:0];
  localparam logic [31:0] CAP32 = CAP64[31:0];

  front_state_t state, state_next;
  logic [1:0]    req_r;
  logic [63:0]   key_r;
  logic [31:0]   val_r;
  logic [63:0]   a;
  logic [63:0]   acc;
  logic [2:0]    ph;
  logic [63:0]   zs;
  logic [2:0]    md;
  logic [31:0]   qe;
  logic [AW:0]   re;
  logic [AW-1:0] rem;

  logic [63:0] h0, cst, prod, sum, mix27, mix31;
  logic [31:0] ma, mb;
  logic [63:0] fold, bprod, rprod, diff;

  assign h0 = {3'b000, key[63:3]};
  assign cst = (ph < 3'd3) ? HASH_C1 : HASH_C2;
  assign prod = ma * mb;

  // 64x64 low product built from three 32x32 partial products, one per cycle
  always_comb begin
    case (ph)
      3'd0, 3'd3: begin
        ma = a[31:0];
        mb = cst[31:0];
        sum = prod;
      end
      3'd1, 3'd4: begin
        ma = a[31:0];
        mb = cst[63:32];
        sum = acc + {prod[31:0], 32'd0};
      end
      default: begin
        ma = a[63:32];
        mb = cst[31:0];
        sum = acc + {prod[31:0], 32'd0};
      end
    endcase
  end

  assign mix27 = sum ^ (sum >> 27);
  assign mix31 = sum ^ (sum >> 31);

  // slot reduction: four folds of the top word by 2^32 mod CAPACITY bring the
  // hash under 2^32, then a reciprocal estimate and one compare and subtract
  assign fold = {32'd0, zs[63:32]} * {32'd0, R32W} + {32'd0, zs[31:0]};
  assign bprod = {32'd0, zs[31:0]} * {32'd0, BMW};
  assign rprod = {32'd0, qe} * {32'd0, CAP32};
  assign diff = {32'd0, zs[31:0]} - rprod;

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (in_valid) state_next = F_HASH;
      F_HASH: if (ph == 3'd5) state_next = F_MOD;
      F_MOD:  if (POW2 || md == 3'd6) state_next = F_PUSH;
      F_PUSH: if (push_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == F_IDLE);
    push_valid = (state == F_PUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        req_r <= req_type;
        key_r <= key;
        val_r <= value_index;
        a <= h0 ^ (h0 >> 30);
        ph <= 3'd0;
      end
      F_HASH: begin
        acc <= sum;
        ph <= ph + 3'd1;
        if (ph == 3'd2) a <= mix27;
        if (ph == 3'd5) begin
          zs <= mix31;
          md <= 3'd0;
        end
      end
      F_MOD: begin
        if (POW2) begin
          rem <= zs[AW-1:0];
        end else begin
          md <= md + 3'd1;
          if (md < 3'd4) begin
            zs <= fold;
          end else if (md == 3'd4) begin
            qe <= bprod[63:32];
          end else if (md == 3'd5) begin
            re <= diff[AW:0];
          end else begin
            rem <= (re >= CAPW) ? AW'(re - CAPW) : re[AW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign push_req = req_r;
  assign push_key = key_r;
  assign push_value = val_r;
  assign push_home = rem;

endmodule

/* design/rhh_fifo.sv */
// Two-entry queue between the front end and the table engine.
module rhh_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  logic [WIDTH-1:0] slot [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic do_push, do_pop;

  assign push_ready = (cnt != 2'd2);
  assign pop_valid = (cnt != 2'd0);
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;
  assign pop_data = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wp] <= push_data;
  end

endmodule

/* design/rhh_back.sv */
// Table engine: probe walks, Robin Hood insert and backward-shift remove.
module rhh_back #(
  parameter int CAPACITY = rhh_pkg::CAPACITY_DEF,
  parameter int AW = $clog2(CAPACITY),
  parameter int CW = $clog2(CAPACITY + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [rhh_pkg::CFG_W-1:0] max_entries,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  logic [1:0]              q_req,
  input  logic [63:0]             q_key,
  input  logic [31:0]             q_value,
  input  logic [AW-1:0]           q_home,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              status,
  output logic [31:0]             found_value,
  output rhh_pkg::rhh_stat_t      stat
);
  import rhh_pkg::*;

  localparam int CMPW = ((CW > CFG_W) ? CW : CFG_W) + 1;
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAPN = CW'(CAPACITY);

  rhh_entry_t mem [CAPACITY];
  rhh_entry_t rd;

  back_state_t state, state_next;
  logic [1:0]    op;
  logic [63:0]   ck;
  logic [31:0]   cv;
  logic [7:0]    cd;
  logic [AW-1:0] s, t, clr;
  logic [CW-1:0] n, count;
  status_t       st_r;
  logic [31:0]   fv;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  rhh_entry_t    wdata;

  logic full, free, hit, stop_find, stop_shift;
  logic [AW-1:0] s_step, t_step;

  assign s_step = (s == LAST) ? '0 : s + 1'b1;
  assign t_step = (t == LAST) ? '0 : t + 1'b1;
  assign full = (CMPW'(count) + CMPW'(1) > CMPW'(max_entries)) || (count >= CAPN);
  assign free = !out_valid || out_ready;
  assign hit = rd.valid && (rd.key == ck);
  assign stop_find = (n == CAPN) || !rd.valid || (rd.pdist < cd);
  assign stop_shift = (n == CAPN) || !rd.valid || (rd.pdist == 8'd0);

  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR: if (clr == LAST) state_next = B_IDLE;
      B_IDLE: begin
        if (q_valid) begin
          if ((q_req == REQ_INSERT && full) || q_req == REQ_NONE) state_next = B_DONE;
          else state_next = B_READ;
        end
      end
      B_READ: state_next = B_EVAL;
      B_EVAL: begin
        if (op == REQ_INSERT) begin
          if (!rd.valid || rd.key == ck) state_next = B_DONE;
          else state_next = B_READ;
        end else if (stop_find) begin
          state_next = B_DONE;
        end else if (hit) begin
          state_next = (op == REQ_REMOVE) ? B_SREAD : B_DONE;
        end else begin
          state_next = B_READ;
        end
      end
      B_SREAD: state_next = B_SEVAL;
      B_SEVAL: state_next = stop_shift ? B_DONE : B_SREAD;
      B_DONE:  if (free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state == B_IDLE);
    raddr = (state == B_SREAD) ? t : s;
    we = 1'b0;
    waddr = s;
    wdata = '{valid: 1'b1, pdist: cd, value: cv, key: ck};
    stat.clearing = (state == B_CLEAR);
    stat.busy = (state != B_IDLE) && (state != B_CLEAR);
    stat.load = (state == B_DONE) && free;
    case (state)
      B_CLEAR: begin
        we = 1'b1;
        waddr = clr;
        wdata = '0;
      end
      B_EVAL: begin
        if (op == REQ_INSERT) begin
          if (rd.valid && rd.key == ck) begin
            we = 1'b1;
            wdata = '{valid: 1'b1, pdist: rd.pdist, value: cv, key: rd.key};
          end else if (!rd.valid || rd.pdist < cd) begin
            we = 1'b1;
          end
        end
      end
      B_SEVAL: begin
        we = 1'b1;
        if (stop_shift) wdata = '0;
        else wdata = '{valid: 1'b1, pdist: dist_dec(rd.pdist), value: rd.value, key: rd.key};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
      clr <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) clr <= clr + 1'b1;
      if (state == B_EVAL && op == REQ_INSERT && !rd.valid) count <= count + 1'b1;
      if (state == B_SEVAL && stop_shift && count != '0) count <= count - 1'b1;
      if (state == B_DONE && free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        op <= q_req;
        ck <= q_key;
        cv <= q_value;
        cd <= 8'd0;
        s <= q_home;
        n <= '0;
        fv <= '0;
        st_r <= (q_req == REQ_INSERT) ? ST_FULL : ST_MISS;
      end
      B_EVAL: begin
        if (op == REQ_INSERT) begin
          if (!rd.valid) begin
            st_r <= ST_INSERTED;
          end else if (rd.key == ck) begin
            st_r <= ST_UPDATED;
          end else begin
            // displaced entry is carried on
            if (rd.pdist < cd) begin
              ck <= rd.key;
              cv <= rd.value;
              cd <= dist_bump(rd.pdist);
            end else begin
              cd <= dist_bump(cd);
            end
            s <= s_step;
          end
        end else if (stop_find) begin
          st_r <= ST_MISS;
        end else if (hit) begin
          fv <= rd.value;
          st_r <= (op == REQ_REMOVE) ? ST_REMOVED : ST_HIT;
          t <= s_step;
          n <= '0;
        end else begin
          s <= s_step;
          cd <= dist_bump(cd);
          n <= n + 1'b1;
        end
      end
      B_SEVAL: begin
        if (!stop_shift) begin
          s <= t;
          t <= t_step;
          n <= n + 1'b1;
        end
      end
      B_DONE: begin
        if (free) begin
          status <= st_r;
          found_value <= fv;
        end
      end
      default: ;
    endcase
  end

endmodule

/* design/robin_hood_hash_map.sv */
// Robin Hood hash map top level: front end, request queue and table engine.
// A request is hashed in the front end and reduced to a home slot by its low
// bits when CAPACITY is a power of two, or otherwise by four folds, a
// reciprocal estimate and a final subtract, and the front end takes no new
// request until it has pushed the last one into the queue; this overlaps with
// the table engine working on the previous request. The engine spends a read
// and a registered compare and write per probed slot on its table memory
// (one read and one write port), plus a start and a report state, and for a
// remove a read and a write per entry shifted back plus a last read and write
// to find the end of the run. At moderate load probes are short, so the front
// end sets the rate. After reset the engine clears every slot before its first
// request; the load limit register may be written at any time the block is idle.
`include "robin_hood_hash_map_macros.svh"

module robin_hood_hash_map #(
  parameter int CAPACITY = rhh_pkg::CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rhh_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                req_type,
  input  logic [63:0]               key,
  input  logic [31:0]               value_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                status,
  output logic [31:0]               found_value
);
  import rhh_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int QW = 2 + 64 + 32 + AW;

  logic [CFG_W-1:0] max_entries;

  logic          f_valid, f_ready;
  logic [1:0]    f_req;
  logic [63:0]   f_key;
  logic [31:0]   f_value;
  logic [AW-1:0] f_home;

  logic          q_valid, q_ready;
  logic [QW-1:0] q_data;
  logic          q_pop;
  rhh_stat_t     bstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_ENTRIES_RST;
    end else if (cfg_valid) begin
      max_entries <= cfg_data;
    end
  end

  rhh_front #(.CAPACITY(CAPACITY), .AW(AW)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .key(key), .value_index(value_index),
    .push_valid(f_valid), .push_ready(f_ready),
    .push_req(f_req), .push_key(f_key), .push_value(f_value), .push_home(f_home)
  );

  rhh_fifo #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst(rst),
    .push_valid(f_valid), .push_ready(f_ready),
    .push_data({f_req, f_key, f_value, f_home}),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_data)
  );

  rhh_back #(.CAPACITY(CAPACITY), .AW(AW)) u_back (
    .clk(clk), .rst(rst),
    .max_entries(max_entries),
    .q_valid(q_valid), .q_ready(q_ready),
    .q_req(q_data[QW-1 -: 2]),
    .q_key(q_data[AW+95 -: 64]),
    .q_value(q_data[AW+31 -: 32]),
    .q_home(q_data[AW-1:0]),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .found_value(found_value),
    .stat(bstat)
  );

  assign q_pop = q_valid && q_ready;

  `RHH_ASSERT_NOW(a_no_pop_in_clear, bstat.clearing, !q_pop, "request taken during clear pass")
  `RHH_ASSERT_NEXT(a_pop_starts_work, q_pop, bstat.busy, "popped request not worked on")
  `RHH_ASSERT_NEXT(a_load_shows_result, bstat.load, out_valid, "result loaded but not offered")

endmodule
